// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on the rising clock, disabled while reset is low
`define TCP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion sampled on the rising clock, checked during reset too
`define TCP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tcp_pkg.sv
// types and constants of the turbo code puncturer
package tcp_pkg;

  // configuration limits
  localparam int unsigned MAX_INFO_LEN = 8192;
  localparam int unsigned MAX_PERIOD   = 32;
  localparam int unsigned MAX_TAIL_LEN = 64;

  // field widths
  localparam int unsigned CNT_W     = 14;
  localparam int unsigned TAIL_W    = 7;
  localparam int unsigned PER_W     = 6;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned PAT_W     = 32;
  localparam int unsigned SEC_W     = 3;
  localparam int unsigned COMP_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFERED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INFO_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_SYS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_PAR1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_PAR2 = 3'd6;

  // section codes; interleaved layout uses data and tail only
  localparam logic [SEC_W-1:0] SEC_SYS       = 3'd0;
  localparam logic [SEC_W-1:0] SEC_SYS_TAIL  = 3'd1;
  localparam logic [SEC_W-1:0] SEC_PAR1      = 3'd2;
  localparam logic [SEC_W-1:0] SEC_PAR1_TAIL = 3'd3;
  localparam logic [SEC_W-1:0] SEC_GAP       = 3'd4;
  localparam logic [SEC_W-1:0] SEC_PAR2      = 3'd5;
  localparam logic [SEC_W-1:0] SEC_PAR2_TAIL = 3'd6;
  localparam logic [SEC_W-1:0] SEC_IL_DATA   = SEC_SYS;
  localparam logic [SEC_W-1:0] SEC_IL_TAIL   = SEC_SYS_TAIL;

  // component codes inside an interleaved triple
  localparam logic [COMP_W-1:0] COMP_SYS  = 2'd0;
  localparam logic [COMP_W-1:0] COMP_PAR1 = 2'd1;
  localparam logic [COMP_W-1:0] COMP_PAR2 = 2'd2;

  // configuration, held already clamped to its legal range
  typedef struct packed {
    logic              buffered;
    logic [CNT_W-1:0]  info_len;
    logic [TAIL_W-1:0] tail_len;
    logic [PER_W-1:0]  period;
    logic [PAT_W-1:0]  pat_sys;
    logic [PAT_W-1:0]  pat_par1;
    logic [PAT_W-1:0]  pat_par2;
  } cfg_t;

  // drop or pass decision for the current beat
  typedef struct packed {
    logic keep;
    logic frame_start;
  } decision_t;

endpackage

// File: rtl/tcp_if.sv
// valid/ready channels of the turbo code puncturer
interface tcp_in_if;
  logic valid;
  logic ready;
  logic coded_bit;

  modport source (output valid, output coded_bit, input ready);
  modport sink (input valid, input coded_bit, output ready);
endinterface

interface tcp_out_if;
  logic valid;
  logic ready;
  logic kept_bit;
  logic frame_start;

  modport source (output valid, output kept_bit, output frame_start, input ready);
  modport sink (input valid, input kept_bit, input frame_start, output ready);
endinterface

// File: rtl/tcp_cfg.sv
// configuration registers with range clamping on write
module tcp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcp_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  output tcp_pkg::cfg_t                  cfg_o
);
  import tcp_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [CNT_W-1:0]  k_raw;
  logic [TAIL_W-1:0] t_raw;
  logic [PER_W-1:0]  p_raw;

  assign k_raw = cfg_wdata_i[CNT_W-1:0];
  assign t_raw = cfg_wdata_i[TAIL_W-1:0];
  assign p_raw = cfg_wdata_i[PER_W-1:0];

  // write decode, values clamped into range
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BUFFERED: cfg_d.buffered = cfg_wdata_i[0];
        REG_INFO_LEN: begin
          if (k_raw == '0) begin
            cfg_d.info_len = CNT_W'(1);
          end else if (k_raw > CNT_W'(MAX_INFO_LEN)) begin
            cfg_d.info_len = CNT_W'(MAX_INFO_LEN);
          end else begin
            cfg_d.info_len = k_raw;
          end
        end
        REG_TAIL_LEN: begin
          if (t_raw > TAIL_W'(MAX_TAIL_LEN)) begin
            cfg_d.tail_len = TAIL_W'(MAX_TAIL_LEN);
          end else begin
            cfg_d.tail_len = t_raw;
          end
        end
        REG_PERIOD: begin
          if (p_raw == '0) begin
            cfg_d.period = PER_W'(1);
          end else if (p_raw > PER_W'(MAX_PERIOD)) begin
            cfg_d.period = PER_W'(MAX_PERIOD);
          end else begin
            cfg_d.period = p_raw;
          end
        end
        REG_PAT_SYS:  cfg_d.pat_sys  = cfg_wdata_i[PAT_W-1:0];
        REG_PAT_PAR1: cfg_d.pat_par1 = cfg_wdata_i[PAT_W-1:0];
        REG_PAT_PAR2: cfg_d.pat_par2 = cfg_wdata_i[PAT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // register bank with default values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffered <= 1'b0;
      cfg_q.info_len <= CNT_W'(40);
      cfg_q.tail_len <= TAIL_W'(12);
      cfg_q.period   <= PER_W'(1);
      cfg_q.pat_sys  <= PAT_W'(1);
      cfg_q.pat_par1 <= PAT_W'(1);
      cfg_q.pat_par2 <= PAT_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tcp_core.sv
// codeword position tracking and keep decision
module tcp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcp_pkg::cfg_t       cfg_i,
  input  logic                fire_i,
  output tcp_pkg::decision_t  dec_o
);
  import tcp_pkg::*;

  // a finished section, then at most two empty ones, before a non-empty data section
  localparam int unsigned NORM_STEPS = 3;

  typedef struct packed {
    logic [SEC_W-1:0]  section;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  pos;
    logic [COMP_W-1:0] comp;
    logic              has_out;
  } pos_state_t;

  pos_state_t        st_q, st_d, cur, stepped;
  logic [PAT_W-1:0]  pat;
  logic              pat_bit;
  logic              keep;
  logic [POS_W-1:0]  pos_adv;

  // length of one section under the current layout
  function automatic logic [CNT_W-1:0] sec_len(logic [SEC_W-1:0] sec, cfg_t c);
    logic [CNT_W-1:0] len;
    len = '0;
    if (!c.buffered) begin
      if (sec == SEC_IL_DATA) begin
        len = c.info_len;
      end else if (sec == SEC_IL_TAIL) begin
        len = CNT_W'(c.tail_len);
      end
    end else begin
      unique case (sec)
        SEC_SYS, SEC_PAR1, SEC_PAR2: len = c.info_len;
        SEC_SYS_TAIL, SEC_PAR2_TAIL: len = CNT_W'(c.tail_len >> 2);
        SEC_PAR1_TAIL:               len = CNT_W'(c.tail_len >> 1);
        SEC_GAP:  len = CNT_W'(c.tail_len[1:0] - {1'b0, c.tail_len[1]});
        default:  len = '0;
      endcase
    end
    return len;
  endfunction

  // move past finished and empty sections; the first data section is never empty
  function automatic pos_state_t normalize(pos_state_t s, cfg_t c);
    pos_state_t       r;
    logic [SEC_W-1:0] last;
    r    = s;
    last = c.buffered ? SEC_PAR2_TAIL : SEC_IL_TAIL;
    for (int i = 0; i < NORM_STEPS; i++) begin
      if (r.count >= sec_len(r.section, c)) begin
        if (r.section >= last) begin
          r.section = SEC_SYS;
          r.has_out = 1'b0;
        end else begin
          r.section = r.section + SEC_W'(1);
        end
        r.count = '0;
        r.pos   = '0;
        r.comp  = COMP_SYS;
      end
    end
    return r;
  endfunction

  // position as seen under the registers now in force
  assign cur = normalize(st_q, cfg_i);

  // next period position, wrapping at the period length
  assign pos_adv = ({1'b0, cur.pos} + PER_W'(1) >= cfg_i.period) ?
                   '0 : cur.pos + POS_W'(1);

  // pattern for the current component
  always_comb begin
    pat = cfg_i.pat_sys;
    if (!cfg_i.buffered) begin
      unique case (cur.comp)
        COMP_PAR1: pat = cfg_i.pat_par1;
        COMP_PAR2: pat = cfg_i.pat_par2;
        default:   pat = cfg_i.pat_sys;
      endcase
    end else if (cur.section == SEC_PAR1) begin
      pat = cfg_i.pat_par1;
    end else if (cur.section == SEC_PAR2) begin
      pat = cfg_i.pat_par2;
    end
  end

  assign pat_bit = pat[cur.pos];

  // one codeword bit: decide and advance
  always_comb begin
    stepped = cur;
    keep    = 1'b1;
    if (!cfg_i.buffered) begin
      if (cur.section == SEC_IL_DATA) begin
        keep = pat_bit;
        if (cur.comp >= COMP_PAR2) begin
          stepped.comp  = COMP_SYS;
          stepped.count = cur.count + CNT_W'(1);
          stepped.pos   = pos_adv;
        end else begin
          stepped.comp = cur.comp + COMP_W'(1);
        end
      end else begin
        stepped.count = cur.count + CNT_W'(1);
      end
    end else begin
      if (cur.section == SEC_SYS || cur.section == SEC_PAR1 ||
          cur.section == SEC_PAR2) begin
        keep        = pat_bit;
        stepped.pos = pos_adv;
      end else begin
        keep = (cur.section != SEC_GAP);
      end
      stepped.count = cur.count + CNT_W'(1);
    end
    if (keep) begin
      stepped.has_out = 1'b1;
    end
  end

  assign st_d = fire_i ? normalize(stepped, cfg_i) : st_q;

  // position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign dec_o.keep        = keep;
  assign dec_o.frame_start = !cur.has_out;

endmodule

// File: rtl/tcp_out_stage.sv
// result register between the decision and the output channel
module tcp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                coded_bit_i,
  input  tcp_pkg::decision_t  dec_i,
  output logic                take_o,
  tcp_out_if.source           out_o
);
  import tcp_pkg::*;

  logic valid_q, valid_d;
  logic bit_q, start_q;

  // room for a new beat when empty or when the held beat leaves now
  assign take_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = dec_i.keep;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  // beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // beat payload
  always_ff @(posedge clk_i) begin
    if (fire_i && dec_i.keep) begin
      bit_q   <= coded_bit_i;
      start_q <= dec_i.frame_start;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kept_bit    = bit_q;
  assign out_o.frame_start = start_q;

endmodule

// File: rtl/turbo_code_puncturer.sv
// turbo code puncturer top level
// a kept bit appears on the output in the cycle after its input beat is taken
// throughput: one input beat per cycle; a dropped bit yields no output beat
// the input stalls only while the result register holds a beat not yet taken
// reset clears the codeword position and result register, registers take defaults
module turbo_code_puncturer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcp_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  tcp_in_if.sink                         coded_i,
  tcp_out_if.source                      kept_o
);
  import tcp_pkg::*;

  cfg_t      cfg;
  decision_t dec;
  logic      take;
  logic      fire;

  // input beat handshake
  assign coded_i.ready = take;
  assign fire          = coded_i.valid && take;

  // configuration registers
  tcp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // position tracking and keep decision
  tcp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .dec_o  (dec)
  );

  // result register
  tcp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .coded_bit_i (coded_i.coded_bit),
    .dec_i       (dec),
    .take_o      (take),
    .out_o       (kept_o)
  );

endmodule

// File: rtl/tcp_checker.sv
// port-level checks of the turbo code puncturer and their binding
`include "assert_macros.svh"

module tcp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic coded_bit_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic kept_bit_i
);

  // held output beat stays until taken
  `TCP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "output beat dropped while stalled")

  // a stalled output blocks the input
  `TCP_ASSERT(a_in_block, clk_i, rst_ni, out_valid_i && !out_ready_i |-> !in_ready_i, "input taken while result register full")

  // a new output beat comes only from an accepted input beat
  `TCP_ASSERT(a_out_source, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i), "output beat without input beat")

  // a new output beat carries the bit accepted in the cycle before
  `TCP_ASSERT(a_out_data, clk_i, rst_ni, $rose(out_valid_i) |-> kept_bit_i == $past(coded_bit_i), "output bit differs from input bit")

  // no output beat during reset
  `TCP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "output valid during reset")

endmodule

bind turbo_code_puncturer tcp_checker u_tcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (coded_i.valid),
  .in_ready_i    (coded_i.ready),
  .coded_bit_i   (coded_i.coded_bit),
  .out_valid_i   (kept_o.valid),
  .out_ready_i   (kept_o.ready),
  .kept_bit_i    (kept_o.kept_bit)
);

// File: dv/turbo_code_puncturer_test.sv
// testbench of the turbo code puncturer: random codeword streams checked beat by beat
module turbo_code_puncturer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PRESSURE_PH   = 2;

  // one kept output beat as the block should deliver it
  typedef struct packed {
    logic kept_bit;
    logic frame_start;
  } kept_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  tcp_in_if  coded_if ();
  tcp_out_if kept_if ();

  turbo_code_puncturer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coded_i     (coded_if),
    .kept_o      (kept_if)
  );

  // codeword bits waiting to be sent, kept beats waiting to come out
  logic       coded_q[$];
  kept_beat_t kept_q[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_idle_on;
  bit          out_idle_on;
  logic        rx_hold;

  // register mirror
  logic              cfg_buffered;
  logic [CNT_W-1:0]  cfg_info_len;
  logic [TAIL_W-1:0] cfg_tail_len;
  logic [PER_W-1:0]  cfg_period;
  logic [PAT_W-1:0]  cfg_pat[3];

  // codeword position
  logic [SEC_W-1:0]  cur_sec;
  int unsigned       sec_pos;
  int unsigned       per_pos;
  logic [COMP_W-1:0] cur_comp;
  bit                frame_seen;

  always #5ns clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    $display("%0t ns  %s", $realtime, what);
    errors++;
  endtask

  function automatic void restore_defaults();
    cfg_buffered = 1'b0;
    cfg_info_len = CNT_W'(40);
    cfg_tail_len = TAIL_W'(12);
    cfg_period   = PER_W'(1);
    cfg_pat[COMP_SYS]  = PAT_W'(1);
    cfg_pat[COMP_PAR1] = PAT_W'(1);
    cfg_pat[COMP_PAR2] = PAT_W'(1);
    cur_sec    = SEC_SYS;
    sec_pos    = 0;
    per_pos    = 0;
    cur_comp   = COMP_SYS;
    frame_seen = 1'b0;
  endfunction

  // effective sizes after clamping
  function automatic int unsigned eff_info_len();
    int unsigned k;
    k = cfg_info_len;
    if (k == 0) k = 1;
    if (k > MAX_INFO_LEN) k = MAX_INFO_LEN;
    return k;
  endfunction

  function automatic int unsigned eff_tail_len();
    return (cfg_tail_len > MAX_TAIL_LEN) ? MAX_TAIL_LEN : cfg_tail_len;
  endfunction

  function automatic int unsigned eff_period();
    int unsigned p;
    p = cfg_period;
    if (p == 0) p = 1;
    if (p > MAX_PERIOD) p = MAX_PERIOD;
    if (p > PAT_W) p = PAT_W;
    return p;
  endfunction

  function automatic int unsigned section_len(logic [SEC_W-1:0] s);
    int unsigned k;
    int unsigned t;
    k = eff_info_len();
    t = eff_tail_len();
    if (!cfg_buffered) begin
      if (s == SEC_IL_DATA) return k;
      if (s == SEC_IL_TAIL) return t;
      return 0;
    end
    case (s)
      SEC_SYS, SEC_PAR1, SEC_PAR2: return k;
      SEC_SYS_TAIL, SEC_PAR2_TAIL: return t / 4;
      SEC_PAR1_TAIL:               return t / 2;
      SEC_GAP:                     return t - 2 * (t / 4) - t / 2;
      default:                     return 0;
    endcase
  endfunction

  // step over finished or empty sections; passing the last one opens a new frame
  function automatic void skip_done_sections();
    logic [SEC_W-1:0] last_sec;
    last_sec = cfg_buffered ? SEC_PAR2_TAIL : SEC_IL_TAIL;
    while (sec_pos >= section_len(cur_sec)) begin
      if (cur_sec >= last_sec) begin
        cur_sec    = SEC_SYS;
        frame_seen = 1'b0;
      end else begin
        cur_sec = cur_sec + 1'b1;
      end
      sec_pos  = 0;
      per_pos  = 0;
      cur_comp = COMP_SYS;
    end
  endfunction

  function automatic logic pattern_keeps(logic [COMP_W-1:0] comp);
    if (per_pos >= PAT_W) return 1'b0;
    return cfg_pat[comp][per_pos];
  endfunction

  // a position left above a shortened period wraps on its next step
  function automatic void step_period();
    per_pos = (per_pos + 1 >= eff_period()) ? 0 : per_pos + 1;
  endfunction

  // decide one codeword bit and queue the kept beat it causes
  function automatic void predict_kept(logic coded_bit);
    logic keep;
    skip_done_sections();
    if (!cfg_buffered) begin
      if (cur_sec == SEC_IL_DATA) begin
        keep = pattern_keeps(cur_comp);
        if (cur_comp == COMP_PAR2) begin
          cur_comp = COMP_SYS;
          sec_pos++;
          step_period();
        end else begin
          cur_comp = cur_comp + 1'b1;
        end
      end else begin
        keep = 1'b1;
        sec_pos++;
      end
    end else begin
      case (cur_sec)
        SEC_SYS: begin
          keep = pattern_keeps(COMP_SYS);
          step_period();
        end
        SEC_PAR1: begin
          keep = pattern_keeps(COMP_PAR1);
          step_period();
        end
        SEC_PAR2: begin
          keep = pattern_keeps(COMP_PAR2);
          step_period();
        end
        SEC_GAP: keep = 1'b0;
        default: keep = 1'b1;
      endcase
      sec_pos++;
    end
    if (keep) begin
      kept_q.push_back('{kept_bit: coded_bit, frame_start: !frame_seen});
      frame_seen = 1'b1;
    end
    skip_done_sections();
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // zero, the limit, all ones, or a small typical size
  function automatic logic [CFG_DAT_W-1:0] pick_size(int unsigned top, int unsigned lo,
                                                     int unsigned hi);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return top;
      2:       return '1;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_reg(logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DAT_W-1:0] v;
    logic [CFG_DAT_W-1:0] used;
    case (idx)
      REG_BUFFERED: begin
        v    = $urandom_range(0, 1);
        used = 1;
      end
      REG_INFO_LEN: begin
        v    = pick_size(MAX_INFO_LEN, 1, 12);
        used = {CFG_DAT_W{1'b1}} >> (CFG_DAT_W - CNT_W);
      end
      REG_TAIL_LEN: begin
        v    = pick_size(MAX_TAIL_LEN, 0, 16);
        used = {CFG_DAT_W{1'b1}} >> (CFG_DAT_W - TAIL_W);
      end
      REG_PERIOD: begin
        v    = pick_size(MAX_PERIOD, 1, 8);
        used = {CFG_DAT_W{1'b1}} >> (CFG_DAT_W - PER_W);
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       v = '0;
          1:       v = '1;
          default: v = $urandom;
        endcase
        used = '1;
      end
    endcase
    // now and then junk above the register width
    if ($urandom_range(0, 7) == 0) return (v & used) | ($urandom & ~used);
    return v & used;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BUFFERED: cfg_buffered = data[0];
      REG_INFO_LEN: cfg_info_len = data[CNT_W-1:0];
      REG_TAIL_LEN: cfg_tail_len = data[TAIL_W-1:0];
      REG_PERIOD:   cfg_period   = data[PER_W-1:0];
      REG_PAT_SYS:  cfg_pat[COMP_SYS]  = data[PAT_W-1:0];
      REG_PAT_PAR1: cfg_pat[COMP_PAR1] = data[PAT_W-1:0];
      REG_PAT_PAR2: cfg_pat[COMP_PAR2] = data[PAT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic buffered, int unsigned info_len, int unsigned tail_len,
                           int unsigned period, logic [PAT_W-1:0] pat_sys,
                           logic [PAT_W-1:0] pat_par1, logic [PAT_W-1:0] pat_par2);
    write_reg(REG_BUFFERED, CFG_DAT_W'(buffered));
    write_reg(REG_INFO_LEN, info_len);
    write_reg(REG_TAIL_LEN, tail_len);
    write_reg(REG_PERIOD, period);
    write_reg(REG_PAT_SYS, pat_sys);
    write_reg(REG_PAT_PAR1, pat_par1);
    write_reg(REG_PAT_PAR2, pat_par2);
  endtask

  task automatic send_bits(int unsigned n);
    repeat (n) coded_q.push_back(1'($urandom_range(0, 1)));
  endtask

  // wait until every bit is in and every kept beat is out, then let the block go quiet
  task automatic settle();
    do @(negedge clk_i);
    while (coded_q.size() != 0 || coded_if.valid || kept_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      coded_if.valid <= 1'b0;
      in_gap         <= 0;
    end else begin
      if (coded_if.valid && coded_if.ready) predict_kept(coded_if.coded_bit);
      if (!coded_if.valid || coded_if.ready) begin
        if (in_gap != 0) begin
          in_gap         <= in_gap - 1;
          coded_if.valid <= 1'b0;
        end else if (coded_q.size() != 0) begin
          coded_if.valid     <= 1'b1;
          coded_if.coded_bit <= coded_q.pop_front();
          in_gap             <= pick_gap(in_idle_on);
        end else begin
          coded_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: compare each beat, then stall at random
  always @(posedge clk_i) begin : kept_monitor
    kept_beat_t exp_beat;
    if (!rst_ni) begin
      kept_if.ready <= 1'b0;
      out_stall     <= 0;
    end else begin
      if (kept_if.valid && kept_if.ready) begin
        if (kept_q.size() == 0) begin
          report_mismatch($sformatf("kept beat with nothing expected, bit %b",
                                    kept_if.kept_bit));
        end else begin
          exp_beat = kept_q.pop_front();
          if (kept_if.kept_bit !== exp_beat.kept_bit)
            report_mismatch($sformatf("kept_bit %b, expected %b",
                                      kept_if.kept_bit, exp_beat.kept_bit));
          if (kept_if.frame_start !== exp_beat.frame_start)
            report_mismatch($sformatf("frame_start %b, expected %b",
                                      kept_if.frame_start, exp_beat.frame_start));
        end
      end
      if (rx_hold) begin
        kept_if.ready <= 1'b0;
      end else if (out_stall != 0) begin
        out_stall     <= out_stall - 1;
        kept_if.ready <= 1'b0;
      end else begin
        kept_if.ready <= 1'b1;
        out_stall     <= pick_gap(out_idle_on);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b1;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_BUFFERED;
    cfg_wdata_i        = '0;
    coded_if.valid     = 1'b0;
    coded_if.coded_bit = 1'b0;
    kept_if.ready      = 1'b0;
    rx_hold            = 1'b0;
    in_idle_on         = 1'b1;
    out_idle_on        = 1'b1;
    errors             = 0;
    cycles             = 0;
    restore_defaults();
    // reset edge after every process waits on it
    #1ns rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // settings after reset
    send_bits(3);
    settle();
    // interleaved, each component with its own pattern, partly dropped
    write_all(1'b0, 2, 2, 2, 32'h1, 32'h2, 32'h0);
    send_bits(8);
    settle();
    // buffered with a leftover gap bit, oversized period
    write_all(1'b1, 1, 5, 63, '1, '1, '1);
    send_bits(9);
    settle();
    // zero info length with junk above it, no tail, zero period, back to interleaved
    write_reg(REG_INFO_LEN, 32'hFFFF_C000);
    write_reg(REG_TAIL_LEN, 0);
    write_reg(REG_PERIOD, 0);
    write_reg(REG_BUFFERED, CFG_DAT_W'(1'b0));
    send_bits(5);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if (ph == PRESSURE_PH) begin
        // every bit kept while the receiver holds off: the block must stall its input
        write_all(1'b1, MAX_INFO_LEN, 127, MAX_PERIOD, '1, '1, '1);
        in_idle_on = 1'b0;
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
        send_bits(100);
      end else begin
        for (int i = REG_BUFFERED; i <= REG_PAT_PAR2; i++)
          if (ph == 0 || $urandom_range(0, 1) != 0)
            write_reg(CFG_IDX_W'(i), pick_reg(CFG_IDX_W'(i)));
        send_bits($urandom_range(60, 100));
      end
      settle();
    end

    if (kept_q.size() != 0)
      report_mismatch($sformatf("%0d kept beats never came out", kept_q.size()));
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
